@@ rtl/hbcd_pkg.sv @@
// Shared types and constants for the hysteresis band classifier with dwell.
// Holds register indexes, reset values and the configuration bundle.
// No dependencies.
`default_nettype none

package hbcd_pkg;

  localparam int unsigned HBCD_COUNT_BITS = 16;
  localparam int unsigned HBCD_TIME_BITS  = 32;

  localparam int unsigned HBCD_SCORE_W   = 16;
  localparam int unsigned HBCD_CFG_W     = 16;
  localparam int unsigned HBCD_DWELL_W   = 24;
  localparam int unsigned HBCD_CNT_OUT_W = 16;
  localparam int unsigned HBCD_CFG_IDX_W = 2;

  localparam logic [HBCD_CFG_W-1:0] HBCD_RST_STEP_INTERVAL  = 16'd64;
  localparam logic [HBCD_CFG_W-1:0] HBCD_RST_RISE_THRESHOLD = 16'd32768;
  localparam logic [HBCD_CFG_W-1:0] HBCD_RST_FALL_THRESHOLD = 16'd19661;
  localparam logic [HBCD_CFG_W-1:0] HBCD_RST_MIN_DWELL      = 16'd256;

  typedef enum logic [HBCD_CFG_IDX_W-1:0] {
    CFG_STEP_INTERVAL  = 2'd0,
    CFG_RISE_THRESHOLD = 2'd1,
    CFG_FALL_THRESHOLD = 2'd2,
    CFG_MIN_DWELL      = 2'd3
  } hbcd_cfg_idx_t;

  typedef struct packed {
    logic [HBCD_CFG_W-1:0] step_interval;
    logic [HBCD_CFG_W-1:0] rise_threshold;
    logic [HBCD_CFG_W-1:0] fall_threshold;
    logic [HBCD_CFG_W-1:0] min_dwell;
  } hbcd_cfg_t;

endpackage

`default_nettype wire

@@ rtl/hbcd_cfg_regs.sv @@
// Configuration register file: step interval, thresholds and minimum dwell.
// Depends on hbcd_pkg.
`default_nettype none

module hbcd_cfg_regs (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              cfg_we,
  input  wire logic [hbcd_pkg::HBCD_CFG_IDX_W-1:0] cfg_index,
  input  wire logic [hbcd_pkg::HBCD_CFG_W-1:0]     cfg_data,
  output hbcd_pkg::hbcd_cfg_t                    cfg
);
  import hbcd_pkg::*;

  hbcd_cfg_t cfg_r;
  hbcd_cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (hbcd_cfg_idx_t'(cfg_index))
        CFG_STEP_INTERVAL:  cfg_nxt.step_interval  = cfg_data;
        CFG_RISE_THRESHOLD: cfg_nxt.rise_threshold = cfg_data;
        CFG_FALL_THRESHOLD: cfg_nxt.fall_threshold = cfg_data;
        CFG_MIN_DWELL:      cfg_nxt.min_dwell      = cfg_data;
        default:            cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.step_interval  <= HBCD_RST_STEP_INTERVAL;
      cfg_r.rise_threshold <= HBCD_RST_RISE_THRESHOLD;
      cfg_r.fall_threshold <= HBCD_RST_FALL_THRESHOLD;
      cfg_r.min_dwell      <= HBCD_RST_MIN_DWELL;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

`default_nettype wire

@@ rtl/hbcd_band_update.sv @@
// Series state: band, dwell and elapsed accumulators, move counters.
// Loads the next state from one sample beat. Depends on hbcd_pkg.
`default_nettype none

module hbcd_band_update #(
  parameter int unsigned COUNT_BITS = hbcd_pkg::HBCD_COUNT_BITS,
  parameter int unsigned TIME_BITS  = hbcd_pkg::HBCD_TIME_BITS
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               load,
  input  wire hbcd_pkg::hbcd_cfg_t                cfg,
  input  wire logic [hbcd_pkg::HBCD_SCORE_W-1:0]  score,
  input  wire logic                               first,
  output logic                                    band,
  output logic [hbcd_pkg::HBCD_DWELL_W-1:0]       dwell,
  output logic [COUNT_BITS-1:0]                   rise_ctr,
  output logic [COUNT_BITS-1:0]                   fall_ctr,
  output logic [TIME_BITS-1:0]                    elapsed,
  output logic [COUNT_BITS:0]                     moves
);
  import hbcd_pkg::*;

  localparam int unsigned MW  = COUNT_BITS + 1;
  localparam int unsigned ESW = TIME_BITS + 1;
  localparam int unsigned DSW = HBCD_DWELL_W + 1;

  logic                    band_r, band_nxt;
  logic [HBCD_DWELL_W-1:0] dwell_r, dwell_nxt;
  logic [COUNT_BITS-1:0]   rise_r, rise_nxt;
  logic [COUNT_BITS-1:0]   fall_r, fall_nxt;
  logic [TIME_BITS-1:0]    elapsed_r, elapsed_nxt;
  logic [MW-1:0]           moves_r, moves_nxt;

  logic                    band_base;
  logic [HBCD_DWELL_W-1:0] dwell_base;
  logic [COUNT_BITS-1:0]   rise_base;
  logic [COUNT_BITS-1:0]   fall_base;
  logic [TIME_BITS-1:0]    elapsed_base;
  logic [MW-1:0]           moves_base;
  logic [DSW-1:0]          dwell_sum;
  logic [HBCD_DWELL_W-1:0] dwell_sat;
  logic [ESW-1:0]          elapsed_sum;
  logic                    may_move;
  logic                    rise_move;
  logic                    fall_move;
  logic                    rise_inc;
  logic                    fall_inc;

  always_comb begin
    // restart the series ahead of this sample
    band_base    = first ? 1'b0 : band_r;
    dwell_base   = first ? '0 : dwell_r;
    rise_base    = first ? '0 : rise_r;
    fall_base    = first ? '0 : fall_r;
    elapsed_base = first ? '0 : elapsed_r;
    moves_base   = first ? '0 : moves_r;

    dwell_sum = {1'b0, dwell_base} + DSW'(cfg.step_interval);
    dwell_sat = dwell_sum[DSW-1] ? '1 : dwell_sum[HBCD_DWELL_W-1:0];
    may_move  = dwell_sat >= HBCD_DWELL_W'(cfg.min_dwell);

    rise_move = !band_base && (score > cfg.rise_threshold) && may_move;
    fall_move = band_base && (score < cfg.fall_threshold) && may_move;
    rise_inc  = rise_move && !(&rise_base);
    fall_inc  = fall_move && !(&fall_base);

    band_nxt  = band_base ^ (rise_move | fall_move);
    dwell_nxt = (rise_move | fall_move) ? '0 : dwell_sat;
    rise_nxt  = rise_base + COUNT_BITS'(rise_inc);
    fall_nxt  = fall_base + COUNT_BITS'(fall_inc);
    moves_nxt = moves_base + MW'(rise_inc | fall_inc);

    elapsed_sum = {1'b0, elapsed_base} + ESW'(cfg.step_interval);
    elapsed_nxt = elapsed_sum[ESW-1] ? '1 : elapsed_sum[TIME_BITS-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      band_r    <= 1'b0;
      dwell_r   <= '0;
      rise_r    <= '0;
      fall_r    <= '0;
      elapsed_r <= '0;
      moves_r   <= '0;
    end else if (load) begin
      band_r    <= band_nxt;
      dwell_r   <= dwell_nxt;
      rise_r    <= rise_nxt;
      fall_r    <= fall_nxt;
      elapsed_r <= elapsed_nxt;
      moves_r   <= moves_nxt;
    end
  end

  assign band     = band_r;
  assign dwell    = dwell_r;
  assign rise_ctr = rise_r;
  assign fall_ctr = fall_r;
  assign elapsed  = elapsed_r;
  assign moves    = moves_r;

endmodule

`default_nettype wire

@@ rtl/hbcd_bound_out.sv @@
// Result stage: moves times minimum dwell against elapsed time, result register.
// Depends on hbcd_pkg.
`default_nettype none

module hbcd_bound_out #(
  parameter int unsigned COUNT_BITS = hbcd_pkg::HBCD_COUNT_BITS,
  parameter int unsigned TIME_BITS  = hbcd_pkg::HBCD_TIME_BITS
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic                                 load,
  input  wire logic                                 drop,
  input  wire logic [hbcd_pkg::HBCD_CFG_W-1:0]      min_dwell,
  input  wire logic                                 band,
  input  wire logic [hbcd_pkg::HBCD_DWELL_W-1:0]    dwell,
  input  wire logic [COUNT_BITS-1:0]                rise_ctr,
  input  wire logic [COUNT_BITS-1:0]                fall_ctr,
  input  wire logic [TIME_BITS-1:0]                 elapsed,
  input  wire logic [COUNT_BITS:0]                  moves,
  input  wire logic                                 last,
  output logic                                      out_valid,
  output logic                                      out_band,
  output logic [hbcd_pkg::HBCD_DWELL_W-1:0]         out_dwell_time,
  output logic [hbcd_pkg::HBCD_CNT_OUT_W-1:0]       out_rise_count,
  output logic [hbcd_pkg::HBCD_CNT_OUT_W-1:0]       out_fall_count,
  output logic                                      out_bound_ok,
  output logic                                      out_done_res
);
  import hbcd_pkg::*;

  localparam int unsigned PROD_W = COUNT_BITS + 1 + HBCD_CFG_W;
  localparam int unsigned CMP_W  = (PROD_W > TIME_BITS) ? PROD_W : TIME_BITS;

  logic [PROD_W-1:0]         prod;
  logic                      bound_ok;

  logic                      vld_r, vld_nxt;
  logic                      band_r;
  logic [HBCD_DWELL_W-1:0]   dwell_r;
  logic [HBCD_CNT_OUT_W-1:0] rise_r;
  logic [HBCD_CNT_OUT_W-1:0] fall_r;
  logic                      bound_ok_r;
  logic                      done_r;

  assign prod     = PROD_W'(moves) * PROD_W'(min_dwell);
  assign bound_ok = CMP_W'(prod) <= CMP_W'(elapsed);

  always_comb begin
    vld_nxt = vld_r;
    if (load) begin
      vld_nxt = 1'b1;
    end else if (drop) begin
      vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      band_r     <= band;
      dwell_r    <= dwell;
      rise_r     <= HBCD_CNT_OUT_W'(rise_ctr);
      fall_r     <= HBCD_CNT_OUT_W'(fall_ctr);
      bound_ok_r <= bound_ok;
      done_r     <= last;
    end
  end

  assign out_valid      = vld_r;
  assign out_band       = band_r;
  assign out_dwell_time = dwell_r;
  assign out_rise_count = rise_r;
  assign out_fall_count = fall_r;
  assign out_bound_ok   = bound_ok_r;
  assign out_done_res   = done_r;

endmodule

`default_nettype wire

@@ rtl/hysteresis_band_classifier_dwell.sv @@
// Top level: hysteresis band classifier with minimum dwell time.
// Uses hbcd_pkg, hbcd_cfg_regs, hbcd_band_update and hbcd_bound_out.
//
//   channel | direction | handshake            | payload
//   in      | sink      | in_valid / in_stall  | in_score, in_first, in_last
//   out     | source    | out_valid / out_stall| out_band .. out_done_res
//   cfg     | sink      | cfg_we               | cfg_index, cfg_data
//
// One beat per cycle sustained while out_stall stays low; a beat is accepted into
// the input register, then updates the series state, then passes the bound check
// into the result register. The band/dwell state loop sets the rate.
// Synchronous reset clears the series state and loads register defaults.
// out_stall backs up through the three stages; in_stall rises only once all hold.
`default_nettype none

module hysteresis_band_classifier_dwell #(
  parameter int unsigned COUNT_BITS = hbcd_pkg::HBCD_COUNT_BITS,
  parameter int unsigned TIME_BITS  = hbcd_pkg::HBCD_TIME_BITS
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic                                 cfg_we,
  input  wire logic [hbcd_pkg::HBCD_CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [hbcd_pkg::HBCD_CFG_W-1:0]      cfg_data,
  input  wire logic                                 in_valid,
  output logic                                      in_stall,
  input  wire logic [hbcd_pkg::HBCD_SCORE_W-1:0]    in_score,
  input  wire logic                                 in_first,
  input  wire logic                                 in_last,
  output logic                                      out_valid,
  input  wire logic                                 out_stall,
  output logic                                      out_band,
  output logic [hbcd_pkg::HBCD_DWELL_W-1:0]         out_dwell_time,
  output logic [hbcd_pkg::HBCD_CNT_OUT_W-1:0]       out_rise_count,
  output logic [hbcd_pkg::HBCD_CNT_OUT_W-1:0]       out_fall_count,
  output logic                                      out_bound_ok,
  output logic                                      out_done_res
);
  import hbcd_pkg::*;

  hbcd_cfg_t cfg;

  logic                    s0_vld_r, s0_vld_nxt;
  logic [HBCD_SCORE_W-1:0] s0_score_r;
  logic                    s0_first_r;
  logic                    s0_last_r;
  logic                    s1_vld_r, s1_vld_nxt;
  logic                    s1_last_r;

  logic s2_free, s1_free, s0_free;
  logic s1_adv, s0_adv, in_acc, out_beat;

  logic                    st_band;
  logic [HBCD_DWELL_W-1:0] st_dwell;
  logic [COUNT_BITS-1:0]   st_rise;
  logic [COUNT_BITS-1:0]   st_fall;
  logic [TIME_BITS-1:0]    st_elapsed;
  logic [COUNT_BITS:0]     st_moves;

  assign out_beat = out_valid && !out_stall;
  assign s2_free  = !out_valid || !out_stall;
  assign s1_adv   = s1_vld_r && s2_free;
  assign s1_free  = !s1_vld_r || s2_free;
  assign s0_adv   = s0_vld_r && s1_free;
  assign s0_free  = !s0_vld_r || s1_free;
  assign in_acc   = in_valid && s0_free;
  assign in_stall = !s0_free;

  always_comb begin
    s0_vld_nxt = s0_vld_r;
    if (in_acc) begin
      s0_vld_nxt = 1'b1;
    end else if (s0_adv) begin
      s0_vld_nxt = 1'b0;
    end
    s1_vld_nxt = s1_vld_r;
    if (s0_adv) begin
      s1_vld_nxt = 1'b1;
    end else if (s1_adv) begin
      s1_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_vld_r <= 1'b0;
      s1_vld_r <= 1'b0;
    end else begin
      s0_vld_r <= s0_vld_nxt;
      s1_vld_r <= s1_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s0_score_r <= in_score;
      s0_first_r <= in_first;
      s0_last_r  <= in_last;
    end
    if (s0_adv) begin
      s1_last_r <= s0_last_r;
    end
  end

  hbcd_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  hbcd_band_update #(
    .COUNT_BITS (COUNT_BITS),
    .TIME_BITS  (TIME_BITS)
  ) u_update (
    .clk      (clk),
    .rst_n    (rst_n),
    .load     (s0_adv),
    .cfg      (cfg),
    .score    (s0_score_r),
    .first    (s0_first_r),
    .band     (st_band),
    .dwell    (st_dwell),
    .rise_ctr (st_rise),
    .fall_ctr (st_fall),
    .elapsed  (st_elapsed),
    .moves    (st_moves)
  );

  hbcd_bound_out #(
    .COUNT_BITS (COUNT_BITS),
    .TIME_BITS  (TIME_BITS)
  ) u_out (
    .clk            (clk),
    .rst_n          (rst_n),
    .load           (s1_adv),
    .drop           (out_beat),
    .min_dwell      (cfg.min_dwell),
    .band           (st_band),
    .dwell          (st_dwell),
    .rise_ctr       (st_rise),
    .fall_ctr       (st_fall),
    .elapsed        (st_elapsed),
    .moves          (st_moves),
    .last           (s1_last_r),
    .out_valid      (out_valid),
    .out_band       (out_band),
    .out_dwell_time (out_dwell_time),
    .out_rise_count (out_rise_count),
    .out_fall_count (out_fall_count),
    .out_bound_ok   (out_bound_ok),
    .out_done_res   (out_done_res)
  );

endmodule

`default_nettype wire

@@ rtl/hbcd_checker.sv @@
// Port-level checks for hysteresis_band_classifier_dwell, attached by bind.
// Depends on hbcd_pkg and the top level's ports.
`default_nettype none

module hbcd_checker (
  input wire logic                                clk,
  input wire logic                                rst_n,
  input wire logic                                in_stall,
  input wire logic                                out_valid,
  input wire logic                                out_stall,
  input wire logic                                out_band,
  input wire logic [hbcd_pkg::HBCD_DWELL_W-1:0]   out_dwell_time,
  input wire logic [hbcd_pkg::HBCD_CNT_OUT_W-1:0] out_rise_count,
  input wire logic [hbcd_pkg::HBCD_CNT_OUT_W-1:0] out_fall_count,
  input wire logic                                out_bound_ok,
  input wire logic                                out_done_res
);
  import hbcd_pkg::*;

  // hold a stalled result beat
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_band)
      && $stable(out_dwell_time) && $stable(out_rise_count)
      && $stable(out_fall_count) && $stable(out_bound_ok)
      && $stable(out_done_res))
    else $error("stalled result beat changed");

  a_rst_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // an empty result register must never back-pressure the input
  a_no_false_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> !in_stall)
    else $error("input stalled with no result pending");

  a_zero_moves_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_rise_count == '0) && (out_fall_count == '0)
      |-> out_bound_ok)
    else $error("bound failed with no moves");

endmodule

bind hysteresis_band_classifier_dwell hbcd_checker u_hbcd_checker (.*);

`default_nettype wire
